// File: src/huffman_tree_walk_decoder_core_defines.svh
// assertion macros for the tree-walk decoder
`ifndef HUFFMAN_TREE_WALK_DECODER_CORE_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define HTWD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define HTWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HTWD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define HTWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/htwd_pkg.sv
package htwd_pkg;

	localparam int IDX_W          = 9;
	localparam int SYM_W          = 8;
	localparam int BYTE_W         = 8;
	localparam int REM_W          = $clog2(BYTE_W + 1);
	localparam int NODE_COUNT_DEF = 512;

	typedef enum logic {
		KIND_DECODE = 1'b0,
		KIND_WRITE  = 1'b1
	} kind_t;

	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic             leaf;
		logic [SYM_W-1:0] symbol;
	} node_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_WALK  = 4'b0010,
		S_LAND  = 4'b0100,
		S_FLUSH = 4'b1000
	} state_t;

endpackage

// File: src/htwd_item_if.sv
interface htwd_item_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [htwd_pkg::BYTE_W-1:0] code_byte;
	logic [htwd_pkg::IDX_W-1:0]  node_index;
	logic [htwd_pkg::IDX_W-1:0]  left_child;
	logic [htwd_pkg::IDX_W-1:0]  right_child;
	logic                        leaf_flag;
	logic [htwd_pkg::SYM_W-1:0]  leaf_symbol;

	modport source (
		output valid, kind, code_byte, node_index, left_child, right_child, leaf_flag,
			leaf_symbol,
		input  ready
	);
	modport sink (
		input  valid, kind, code_byte, node_index, left_child, right_child, leaf_flag,
			leaf_symbol,
		output ready
	);
endinterface

// File: src/htwd_result_if.sv
interface htwd_result_if;
	logic                       valid;
	logic                       ready;
	logic [htwd_pkg::SYM_W-1:0] symbol;
	logic                       last;

	modport source (
		output valid, symbol, last,
		input  ready
	);
	modport sink (
		input  valid, symbol, last,
		output ready
	);
endinterface

// File: src/htwd_node_mem.sv
module htwd_node_mem #(
	parameter int DEPTH = htwd_pkg::NODE_COUNT_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  htwd_pkg::node_t          wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output htwd_pkg::node_t          rd_data
);
	import htwd_pkg::*;

	node_t mem_q [DEPTH];
	node_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/huffman_tree_walk_decoder_core.sv
// Huffman tree-walk decoder. A write transaction (kind 1) loads one node of the code tree into
// a NODE_COUNT-entry table; entry 0 is the root, writes at or above NODE_COUNT are dropped,
// and the table is not cleared after reset, so every node a walk can reach must be written
// first. A decode transaction (kind 0) walks the tree over its eight bits, most significant
// first, one bit per cycle while the result side does not stall: the registered read of the
// node table feeds the next child address, and that read loop sets the pace. After a byte is
// accepted the input is held off until the walk is through (start, eight bits, end of byte),
// longer while the result side stalls, so a new decode is taken only after the last one ends.
// Each leaf reached yields one symbol, with last set on the final symbol of the byte; a byte
// that completes no leaf yields nothing, and a partial walk carries over to the next byte.
`include "huffman_tree_walk_decoder_core_defines.svh"

module huffman_tree_walk_decoder_core #(
	parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	htwd_item_if.sink     item,
	htwd_result_if.source result
);
	import htwd_pkg::*;

	localparam int AW = $clog2(NODE_COUNT);

	state_t            state_q;
	logic [BYTE_W-1:0] byte_q;
	logic [REM_W-1:0]  rem_q;
	logic [IDX_W-1:0]  pos_q;
	logic [IDX_W-1:0]  land_idx_q;
	node_t             cur_q;
	node_t             root_q;
	logic              pend_valid_q;
	logic [SYM_W-1:0]  pend_sym_q;
	logic              out_valid_q;
	logic [SYM_W-1:0]  out_sym_q;
	logic              out_last_q;

	node_t            rd_data;
	node_t            wr_data;
	node_t            cur;
	logic [IDX_W-1:0] cur_pos;
	logic             rd_en;
	logic             wr_en;
	logic [IDX_W-1:0] next_idx;
	logic             next_ok;
	logic             slot_free;
	logic             stall;
	logic             item_acc;
	logic             out_load;

	assign item_acc  = item.valid && item.ready;
	assign wr_en     = item_acc && (item.kind == KIND_WRITE) && (32'(item.node_index) < NODE_COUNT);
	assign wr_data   = '{left: item.left_child, right: item.right_child, leaf: item.leaf_flag,
		symbol: item.leaf_symbol};

	assign slot_free = !out_valid_q || result.ready;
	// a second leaf cannot land while the pending symbol has nowhere to go
	assign stall     = (state_q == S_LAND) && rd_data.leaf && pend_valid_q && !slot_free;

	// node at the walk position: straight from the table read when a step just landed
	always_comb begin
		cur     = cur_q;
		cur_pos = pos_q;
		if (state_q == S_LAND) begin
			cur     = rd_data.leaf ? root_q : rd_data;
			cur_pos = rd_data.leaf ? '0 : land_idx_q;
		end
	end

	assign next_idx = byte_q[BYTE_W-1] ? cur.right : cur.left;
	assign next_ok  = 32'(next_idx) < NODE_COUNT;
	assign rd_en    = ((state_q == S_WALK) || ((state_q == S_LAND) && !stall))
		&& (rem_q != '0) && next_ok;

	// the pending symbol moves out when a newer one lands or the byte ends
	assign out_load = ((state_q == S_LAND) && !stall && rd_data.leaf && pend_valid_q)
		|| ((state_q == S_FLUSH) && pend_valid_q && slot_free);

	htwd_node_mem #(
		.DEPTH(NODE_COUNT)
	) u_node_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(AW'(item.node_index)),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(AW'(next_idx)),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			byte_q       <= '0;
			rem_q        <= '0;
			pos_q        <= '0;
			land_idx_q   <= '0;
			cur_q        <= '0;
			root_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_sym_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						if (item.kind == KIND_WRITE) begin
							// keep the cached root and current node in step with the table
							if (wr_en && (item.node_index == '0)) begin
								root_q <= wr_data;
							end
							if (wr_en && (item.node_index == pos_q)) begin
								cur_q <= wr_data;
							end
						end else begin
							byte_q  <= item.code_byte;
							rem_q   <= REM_W'(BYTE_W);
							state_q <= S_WALK;
						end
					end
				end
				S_WALK, S_LAND: begin
					if (!stall) begin
						if ((state_q == S_LAND) && rd_data.leaf) begin
							pend_valid_q <= 1'b1;
							pend_sym_q   <= rd_data.symbol;
						end
						if ((rem_q != '0) && !next_ok) begin
							// child beyond the table: back to the root, nothing emitted
							pos_q <= '0;
							cur_q <= root_q;
						end else begin
							pos_q <= cur_pos;
							cur_q <= cur;
						end
						if (rem_q == '0) begin
							state_q <= S_FLUSH;
						end else begin
							byte_q <= byte_q << 1;
							rem_q  <= rem_q - 1'b1;
							if (next_ok) begin
								land_idx_q <= next_idx;
								state_q    <= S_LAND;
							end else begin
								state_q <= S_WALK;
							end
						end
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q || slot_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_sym_q   <= '0;
			out_last_q  <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_sym_q   <= pend_sym_q;
			out_last_q  <= (state_q == S_FLUSH);
		end else if (out_valid_q && result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign item.ready    = (state_q == S_IDLE);
	assign result.valid  = out_valid_q;
	assign result.symbol = out_sym_q;
	assign result.last   = out_last_q;

	`HTWD_ASSERT_IMPLIES(a_idle_drained, clk, arst_n, item.ready, !pend_valid_q, "symbol pending at idle")
	`HTWD_ASSERT_IMPLIES(a_root_cached, clk, arst_n, (state_q == S_IDLE) && (pos_q == '0), cur_q == root_q, "current node differs from root at root position")
	`HTWD_ASSERT_NEXT(a_end_of_byte, clk, arst_n, (state_q == S_WALK) && (rem_q == '0), state_q == S_FLUSH, "walk did not end after last bit")

endmodule

// File: test/htwd_symbol_checker.sv
module htwd_symbol_checker #(
	parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	htwd_item_if   item,
	htwd_result_if result,
	output int     fail_count,
	output int     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import htwd_pkg::*;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} decoded_t;

	// shadow of the code tree, only ever read where the stimulus has written
	node_t            tree_mem [NODE_COUNT];
	logic [IDX_W-1:0] walk_node;
	decoded_t         due_symbols [$];
	int               mismatches;

	always @(posedge clk or negedge arst_n) begin : track
		decoded_t         want;
		node_t            cur;
		logic [IDX_W-1:0] pos;
		logic [IDX_W-1:0] nxt;
		logic [SYM_W-1:0] found [BYTE_W];
		int               n_found;
		int               b;

		if (!arst_n) begin
			due_symbols.delete();
			walk_node = '0;
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// results leaving this edge belong to earlier transactions, so retire them first
			if (result.valid && result.ready) begin
				if (due_symbols.size() == 0) begin
					mismatches++;
					$display("%0t ns: symbol %02h last %b with none expected",
						$time, result.symbol, result.last);
				end else begin
					want = due_symbols.pop_front();
					if (result.symbol !== want.symbol) begin
						mismatches++;
						$display("%0t ns: symbol expected %02h got %02h",
							$time, want.symbol, result.symbol);
					end
					if (result.last !== want.last) begin
						mismatches++;
						$display("%0t ns: last expected %b got %b (symbol %02h)",
							$time, want.last, result.last, want.symbol);
					end
				end
			end

			if (item.valid && item.ready) begin
				if (item.kind == KIND_WRITE) begin
					if (item.node_index < NODE_COUNT)
						tree_mem[item.node_index] = node_t'({item.left_child,
							item.right_child, item.leaf_flag, item.leaf_symbol});
				end else begin
					pos = walk_node;
					n_found = 0;
					for (b = BYTE_W - 1; b >= 0; b--) begin
						cur = tree_mem[pos];
						nxt = item.code_byte[b] ? cur.right : cur.left;
						if (nxt >= NODE_COUNT) begin
							pos = '0;
						end else if (tree_mem[nxt].leaf) begin
							found[n_found] = tree_mem[nxt].symbol;
							n_found++;
							pos = '0;
						end else begin
							pos = nxt;
						end
					end
					walk_node = pos;
					for (b = 0; b < n_found; b++)
						due_symbols.push_back('{symbol: found[b], last: (b == n_found - 1)});
				end
			end

			fail_count <= mismatches;
			pending <= due_symbols.size();
		end
	end

endmodule

// File: test/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import htwd_pkg::*;

	localparam int NODE_COUNT   = NODE_COUNT_DEF;
	localparam int ITEM_TARGET  = 265;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_AFTER   = 100;
	localparam int HOLD_CYCLES  = 400;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_BURSTY
	} rx_pattern_t;

	logic clk = 1'b0;
	logic arst_n;

	htwd_item_if   item_bus ();
	htwd_result_if result_bus ();

	int fail_count;
	int pending;
	int accepted = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int burst_left = 0;

	bit was_written [NODE_COUNT];
	int written_q [$];

	huffman_tree_walk_decoder_core #(
		.NODE_COUNT(NODE_COUNT)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_bus),
		.result(result_bus)
	);

	htwd_symbol_checker #(
		.NODE_COUNT(NODE_COUNT)
	) symbol_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_bus),
		.result    (result_bus),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && item_bus.valid && item_bus.ready)
			accepted <= accepted + 1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// offer one transaction, inside bursts separated by random gaps
	task automatic offer_item(input kind_t kind, input logic [BYTE_W-1:0] code,
			input logic [IDX_W-1:0] index, input logic [IDX_W-1:0] left,
			input logic [IDX_W-1:0] right, input logic leaf, input logic [SYM_W-1:0] sym);
		int gap;

		if (burst_left == 0) begin
			gap = ($urandom_range(4) == 0) ? 0 : $urandom_range(6, 1);
			if (gap > 0) begin
				item_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(5) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
		end
		burst_left--;
		item_bus.valid       <= 1'b1;
		item_bus.kind        <= kind;
		item_bus.code_byte   <= code;
		item_bus.node_index  <= index;
		item_bus.left_child  <= left;
		item_bus.right_child <= right;
		item_bus.leaf_flag   <= leaf;
		item_bus.leaf_symbol <= sym;
		do @(posedge clk); while (!item_bus.ready);
		items_sent++;
	endtask

	task automatic write_node(input int index, input int left, input int right,
			input logic leaf, input logic [SYM_W-1:0] sym);
		if (!was_written[index]) begin
			was_written[index] = 1'b1;
			written_q.push_back(index);
		end
		offer_item(KIND_WRITE, BYTE_W'($urandom), IDX_W'(index), IDX_W'(left), IDX_W'(right),
			leaf, sym);
	endtask

	task automatic decode_byte(input logic [BYTE_W-1:0] code);
		offer_item(KIND_DECODE, code, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
			1'($urandom), SYM_W'($urandom));
	endtask

	// grow a random full binary tree from the root, then load it in random order;
	// every child index points inside the tree so no walk can reach an empty entry
	task automatic load_code_tree(input int n_leaves);
		int               link_left  [NODE_COUNT];
		int               link_right [NODE_COUNT];
		logic             is_leaf    [NODE_COUNT];
		bit               in_tree    [NODE_COUNT];
		int               members [$];
		int               tips [$];
		int               kids [2];
		int               pick;
		int               tip;
		int               k;

		members.push_back(0);
		tips.push_back(0);
		in_tree[0] = 1'b1;
		while (tips.size() < n_leaves) begin
			pick = $urandom_range(tips.size() - 1);
			tip = tips[pick];
			tips.delete(pick);
			for (k = 0; k < 2; k++) begin
				do kids[k] = $urandom_range(NODE_COUNT - 1, 1); while (in_tree[kids[k]]);
				in_tree[kids[k]] = 1'b1;
				members.push_back(kids[k]);
				tips.push_back(kids[k]);
			end
			link_left[tip] = kids[0];
			link_right[tip] = kids[1];
			is_leaf[tip] = 1'b0;
		end
		foreach (tips[k]) begin
			is_leaf[tips[k]] = 1'b1;
			link_left[tips[k]] = members[$urandom_range(members.size() - 1)];
			link_right[tips[k]] = members[$urandom_range(members.size() - 1)];
		end
		members.shuffle();
		foreach (members[k])
			write_node(members[k], link_left[members[k]], link_right[members[k]],
				is_leaf[members[k]], SYM_W'($urandom));
	endtask

	// result side: changing stall patterns, with one long hold-off to back the block up
	initial begin : receiver
		rx_pattern_t pattern;
		int          span;
		int          hold_left;
		bit          held_once;

		pattern = RX_OPEN;
		span = 0;
		hold_left = 0;
		held_once = 1'b0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				pattern = rx_pattern_t'($urandom_range(3));
				span = $urandom_range(80, 10);
			end
			span--;
			if (!held_once && accepted >= HOLD_AFTER) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				case (pattern)
					RX_OPEN:   result_bus.ready <= 1'b1;
					RX_COIN:   result_bus.ready <= 1'($urandom_range(1));
					RX_SPARSE: result_bus.ready <= (span % 4 == 0);
					default:   result_bus.ready <= (span % 16 < 10);
				endcase
			end
		end
	end

	initial begin : stimulus
		int n_leaves;
		int n_bytes;
		int idx;

		arst_n <= 1'b0;
		item_bus.valid       <= 1'b0;
		item_bus.kind        <= KIND_DECODE;
		item_bus.code_byte   <= '0;
		item_bus.node_index  <= '0;
		item_bus.left_child  <= '0;
		item_bus.right_child <= '0;
		item_bus.leaf_flag   <= 1'b0;
		item_bus.leaf_symbol <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// root marked as leaf and pointing at itself: every bit emits its symbol
		write_node(0, 0, 0, 1'b1, 8'hA5);
		decode_byte(8'h00);
		decode_byte(8'hFF);

		// two leaves, at the highest index and at index 256
		write_node(511, 0, 0, 1'b1, 8'hFF);
		write_node(256, 0, 0, 1'b1, 8'h00);
		write_node(0, 511, 256, 1'b0, 8'h5A);
		decode_byte(8'h00);
		decode_byte(8'hFF);
		decode_byte(8'h5A);

		// node looping on its right child: runs of ones finish no symbol and the
		// partial walk has to carry across bytes
		write_node(3, 0, 0, 1'b1, 8'h3C);
		write_node(5, 3, 5, 1'b0, 8'h81);
		write_node(0, 3, 5, 1'b0, 8'h00);
		decode_byte(8'hFF);
		decode_byte(8'hFF);
		decode_byte(8'h7F);
		decode_byte(8'h00);

		while (items_sent < ITEM_TARGET) begin
			n_leaves = ($urandom_range(5) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 2);
			load_code_tree(n_leaves);
			n_bytes = $urandom_range(16, 4);
			repeat (n_bytes) begin
				if ($urandom_range(11) == 0) begin
					// stray rewrite of a loaded node, links kept among loaded entries
					idx = written_q[$urandom_range(written_q.size() - 1)];
					write_node(idx, written_q[$urandom_range(written_q.size() - 1)],
						written_q[$urandom_range(written_q.size() - 1)],
						1'($urandom_range(1)), SYM_W'($urandom));
				end else begin
					decode_byte(BYTE_W'($urandom));
				end
			end
		end
		item_bus.valid <= 1'b0;

		// the checker's count shows up in the cycle after its edge
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
